// ===== sv/cqbs_pkg.sv =====
// Package of the class queue burst scheduler: widths, limits, codes, types.
// Used by the datapath, controller, top level, checker and testbench; depends on nothing.
package cqbs_pkg;

    localparam int NUM_CLASSES = 5;
    localparam int CLASS_QUEUE_DEPTH = 512;
    localparam int SHARED_FIFO_DEPTH = 4096;
    localparam int MAX_PER_GRANT = 63;
    localparam int CLASS_LIMIT_FIXED = 500;
    localparam int FIFO_LIMIT_FIXED = 3000;
    localparam int CLASS_LIMIT = (CLASS_LIMIT_FIXED < CLASS_QUEUE_DEPTH) ?
                                 CLASS_LIMIT_FIXED : CLASS_QUEUE_DEPTH;
    localparam int FIFO_LIMIT = (FIFO_LIMIT_FIXED < SHARED_FIFO_DEPTH) ?
                                FIFO_LIMIT_FIXED : SHARED_FIFO_DEPTH;

    localparam int CW = $clog2(NUM_CLASSES);
    localparam int CQ_AW = $clog2(CLASS_QUEUE_DEPTH);
    localparam int CQ_CW = $clog2(CLASS_QUEUE_DEPTH + 1);
    localparam int CS_AW = $clog2(NUM_CLASSES * CLASS_QUEUE_DEPTH);
    localparam int SF_AW = $clog2(SHARED_FIFO_DEPTH);
    localparam int SF_CW = $clog2(SHARED_FIFO_DEPTH + 1);
    localparam int NW = $clog2(MAX_PER_GRANT + 1);
    localparam int CQ_DW = 32;
    localparam int SF_DW = 35;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_WRR = 2'd1;
    localparam logic [1:0] MODE_APQ = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_GRANT = 1'b1;

    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_PKT = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [2:0] REG_MODE = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_OUT,
        ST_DONE
    } state_t;

    // Payload of one input item.
    typedef struct packed {
        logic        operation;
        logic [15:0] packet_tag;
        logic [2:0]  traffic_class;
        logic [15:0] packet_length;
        logic [19:0] grant_bytes;
    } sched_in_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [2:0]  cls;
        logic [15:0] len;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        accepted;
        logic [15:0] out_tag;
        logic [2:0]  out_class;
        logic [15:0] out_length;
        logic [19:0] bytes_scheduled;
        logic        last;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic          start;      // clear grant totals
        logic          enq;        // do the enqueue of the held item
        logic          rd;         // read head of the selected queue
        logic          pop;        // take the head just checked
        logic          next_cls;   // move to the next class
        logic          new_round;  // go back to class 0, clear round flags
        logic          skip;       // mark a skip in this round
        logic          fifo_sel;   // serve the shared FIFO
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic fits;          // head packet fits in the remaining capacity
        logic cur_empty;     // selected queue empty
        logic any_pending;   // some class queue holds a packet
        logic under_cap;     // total below capacity
        logic limit_hit;     // grant packet limit reached
        logic weight_done;   // current class used its weight this round
        logic last_cls;      // current class is the last one
        logic round_end;     // a skip or nothing sent in the round
        logic round_sent;    // a packet was sent in this round
    } stat_t;

endpackage

// ===== sv/cqbs_if.sv =====
// Valid/ready channel interface carrying one item of payload type.
// Depends on nothing; payload type given by the user.
interface cqbs_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/cqbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module cqbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== sv/cqbs_datapath.sv =====
// Datapath: queue pointers, the two descriptor memories, grant totals.
// Depends on cqbs_pkg and cqbs_ram.
module cqbs_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cqbs_pkg::cmd_t        cmd,
    output cqbs_pkg::stat_t       stat,
    input  cqbs_pkg::in_item_t    item,
    input  logic [19:0]           cap,
    input  logic [1:0]            mode,
    input  logic [7:0]            weight [cqbs_pkg::NUM_CLASSES],
    output logic                  enq_ok,
    output logic [15:0]           pkt_tag,
    output logic [2:0]            pkt_class,
    output logic [15:0]           pkt_len,
    output logic [19:0]           total
);
    localparam int NC = cqbs_pkg::NUM_CLASSES;

    logic [cqbs_pkg::CQ_AW-1:0] head_reg [NC];
    logic [cqbs_pkg::CQ_AW-1:0] tail_reg [NC];
    logic [cqbs_pkg::CQ_CW-1:0] cnt_reg [NC];
    logic [cqbs_pkg::SF_AW-1:0] fhead_reg, ftail_reg;
    logic [cqbs_pkg::SF_CW-1:0] fcnt_reg;
    logic [cqbs_pkg::CW-1:0]    cls_reg;
    logic [19:0]                total_reg;
    logic [cqbs_pkg::NW-1:0]    n_reg;
    logic [7:0]                 wcnt_reg;
    logic                       skip_reg, sent_reg;

    logic [cqbs_pkg::CQ_DW-1:0] cq_rdata;
    logic [cqbs_pkg::SF_DW-1:0] sf_rdata;
    logic [cqbs_pkg::CW-1:0]    ecls;
    logic                       cls_ok, cq_we, sf_we;
    logic [20:0]                sum;

    assign ecls = item.cls[cqbs_pkg::CW-1:0];
    assign cls_ok = (item.cls < 3'(NC));
    assign sf_we = cmd.enq && cls_ok && (mode == cqbs_pkg::MODE_FIFO)
                   && (fcnt_reg < cqbs_pkg::SF_CW'(cqbs_pkg::FIFO_LIMIT));
    assign cq_we = cmd.enq && cls_ok
                   && (mode == cqbs_pkg::MODE_WRR || mode == cqbs_pkg::MODE_APQ)
                   && (cnt_reg[ecls] < cqbs_pkg::CQ_CW'(cqbs_pkg::CLASS_LIMIT));
    assign enq_ok = sf_we || cq_we;

    cqbs_ram #(.WIDTH(cqbs_pkg::CQ_DW), .DEPTH(NC * cqbs_pkg::CLASS_QUEUE_DEPTH)) u_cq (
        .clk   (clk),
        .we    (cq_we),
        .waddr (cqbs_pkg::CS_AW'(ecls) * cqbs_pkg::CS_AW'(cqbs_pkg::CLASS_QUEUE_DEPTH)
                + cqbs_pkg::CS_AW'(tail_reg[ecls])),
        .wdata ({item.tag, item.len}),
        .re    (cmd.rd),
        .raddr (cqbs_pkg::CS_AW'(cls_reg) * cqbs_pkg::CS_AW'(cqbs_pkg::CLASS_QUEUE_DEPTH)
                + cqbs_pkg::CS_AW'(head_reg[cls_reg])),
        .rdata (cq_rdata)
    );

    cqbs_ram #(.WIDTH(cqbs_pkg::SF_DW), .DEPTH(cqbs_pkg::SHARED_FIFO_DEPTH)) u_sf (
        .clk   (clk),
        .we    (sf_we),
        .waddr (ftail_reg),
        .wdata ({item.cls, item.tag, item.len}),
        .re    (cmd.rd),
        .raddr (fhead_reg),
        .rdata (sf_rdata)
    );

    always_comb
    begin
        if (cmd.fifo_sel)
        begin
            pkt_tag = sf_rdata[31:16];
            pkt_class = sf_rdata[34:32];
            pkt_len = sf_rdata[15:0];
        end
        else
        begin
            pkt_tag = cq_rdata[31:16];
            pkt_class = 3'(cls_reg);
            pkt_len = cq_rdata[15:0];
        end
    end

    assign sum = {1'b0, total_reg} + {5'd0, pkt_len};
    assign total = total_reg;

    always_comb
    begin
        logic any;
        any = 1'b0;
        for (int c = 0; c < NC; c++)
        begin
            any = any | (cnt_reg[c] != '0);
        end
        stat.any_pending = any;
        stat.fits = (sum <= {1'b0, cap});
        stat.cur_empty = cmd.fifo_sel ? (fcnt_reg == '0) : (cnt_reg[cls_reg] == '0);
        stat.under_cap = (total_reg < cap);
        stat.limit_hit = (n_reg == cqbs_pkg::NW'(cqbs_pkg::MAX_PER_GRANT));
        stat.weight_done = (wcnt_reg >= weight[cls_reg]);
        stat.last_cls = (cls_reg == cqbs_pkg::CW'(NC - 1));
        stat.round_end = skip_reg || !sent_reg;
        stat.round_sent = sent_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c] <= '0;
            end
            fhead_reg <= '0;
            ftail_reg <= '0;
            fcnt_reg <= '0;
            cls_reg <= '0;
            total_reg <= '0;
            n_reg <= '0;
            wcnt_reg <= '0;
            skip_reg <= 1'b0;
            sent_reg <= 1'b0;
        end
        else
        begin
            if (sf_we)
            begin
                ftail_reg <= ftail_reg + 1'b1;
                fcnt_reg <= fcnt_reg + 1'b1;
            end
            if (cq_we)
            begin
                tail_reg[ecls] <= tail_reg[ecls] + 1'b1;
                cnt_reg[ecls] <= cnt_reg[ecls] + 1'b1;
            end
            if (cmd.start)
            begin
                total_reg <= '0;
                n_reg <= '0;
                cls_reg <= '0;
                wcnt_reg <= '0;
                skip_reg <= 1'b0;
                sent_reg <= 1'b0;
            end
            if (cmd.new_round)
            begin
                cls_reg <= '0;
                wcnt_reg <= '0;
                skip_reg <= 1'b0;
                sent_reg <= 1'b0;
            end
            if (cmd.next_cls)
            begin
                cls_reg <= cls_reg + 1'b1;
                wcnt_reg <= '0;
            end
            if (cmd.skip)
            begin
                skip_reg <= 1'b1;
            end
            if (cmd.pop)
            begin
                total_reg <= sum[19:0];
                n_reg <= n_reg + 1'b1;
                wcnt_reg <= wcnt_reg + 1'b1;
                sent_reg <= 1'b1;
                if (cmd.fifo_sel)
                begin
                    fhead_reg <= fhead_reg + 1'b1;
                    fcnt_reg <= fcnt_reg - 1'b1;
                end
                else
                begin
                    head_reg[cls_reg] <= head_reg[cls_reg] + 1'b1;
                    cnt_reg[cls_reg] <= cnt_reg[cls_reg] - 1'b1;
                end
            end
        end
    end
endmodule

// ===== sv/cqbs_ctrl.sv =====
// Controller state machine: walks a grant over the queues, issues results.
// Depends on cqbs_pkg.
module cqbs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_op,
    input  logic [1:0]       mode,
    input  cqbs_pkg::stat_t  stat,
    output cqbs_pkg::cmd_t   cmd,
    output logic             out_load,
    output logic [1:0]       out_kind,
    input  logic             out_free
);
    cqbs_pkg::state_t state_reg, state_next;
    logic op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cqbs_pkg::ST_IDLE;
            op_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    always_comb
    begin
        logic wrr, apq, fifo;
        wrr = (mode == cqbs_pkg::MODE_WRR);
        apq = (mode == cqbs_pkg::MODE_APQ);
        fifo = (mode == cqbs_pkg::MODE_FIFO);
        state_next = state_reg;
        op_next = op_reg;
        cmd = '0;
        cmd.fifo_sel = fifo;
        in_ready = 1'b0;
        out_load = 1'b0;
        out_kind = cqbs_pkg::KIND_ENQ;
        case (state_reg)
            cqbs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next = in_op;
                    if (in_op == cqbs_pkg::OP_ENQUEUE)
                    begin
                        state_next = cqbs_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        state_next = cqbs_pkg::ST_READ;
                    end
                end
            end
            cqbs_pkg::ST_READ:
            begin
                // Pick the next queue to look at, or finish the grant. A round robin
                // round tests the capacity only before its first packet is sent.
                if ((!stat.under_cap && (!wrr || !stat.round_sent)) || stat.limit_hit
                    || mode == cqbs_pkg::MODE_DISCARD)
                begin
                    state_next = cqbs_pkg::ST_DONE;
                end
                else if (fifo)
                begin
                    if (stat.cur_empty)
                    begin
                        state_next = cqbs_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.rd = 1'b1;
                        state_next = cqbs_pkg::ST_CHECK;
                    end
                end
                else if (stat.cur_empty || (wrr && stat.weight_done))
                begin
                    if (!stat.last_cls)
                    begin
                        cmd.next_cls = 1'b1;
                    end
                    else if (wrr && !stat.round_end && stat.any_pending)
                    begin
                        cmd.new_round = 1'b1;
                    end
                    else
                    begin
                        state_next = cqbs_pkg::ST_DONE;
                    end
                end
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = cqbs_pkg::ST_CHECK;
                end
            end
            cqbs_pkg::ST_CHECK:
            begin
                if (stat.fits)
                begin
                    state_next = cqbs_pkg::ST_OUT;
                end
                else if (fifo)
                begin
                    state_next = cqbs_pkg::ST_DONE;
                end
                else
                begin
                    cmd.skip = wrr;
                    if (!stat.last_cls)
                    begin
                        cmd.next_cls = 1'b1;
                        state_next = cqbs_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = cqbs_pkg::ST_DONE;
                    end
                end
            end
            cqbs_pkg::ST_OUT:
            begin
                out_kind = cqbs_pkg::KIND_PKT;
                if (out_free)
                begin
                    out_load = 1'b1;
                    cmd.pop = 1'b1;
                    state_next = cqbs_pkg::ST_READ;
                end
            end
            cqbs_pkg::ST_DONE:
            begin
                out_kind = (op_reg == cqbs_pkg::OP_ENQUEUE) ?
                           cqbs_pkg::KIND_ENQ : cqbs_pkg::KIND_DONE;
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = cqbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cqbs_pkg::ST_IDLE;
            end
        endcase
        if (apq)
        begin
            cmd.skip = 1'b0;
        end
    end
endmodule

// ===== sv/class_queue_burst_scheduler.sv =====
// Class queue burst scheduler: FIFO, weighted round robin, strict priority and discard modes.
// An enqueue goes from the idle state to the done state, which loads its status result.
// A grant steps through memory read, fit check and output for each packet and then
// gives its done result, with extra steps per class stepped over or head packet that
// does not fit; a held output register stalls the output and done steps.
// One item is in work at a time. Reset (rst_n low, asynchronous) empties all
// queues and sets FIFO mode with all weights 1; memories need no clearing.
module class_queue_burst_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    cqbs_if.sink        in_ch,
    cqbs_if.source      out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int NC = cqbs_pkg::NUM_CLASSES;

    logic [1:0]          mode_reg;
    logic [7:0]          weight_reg [NC];
    cqbs_pkg::in_item_t  item_reg;
    logic [19:0]         cap_reg;
    cqbs_pkg::cmd_t      cmd;
    cqbs_pkg::stat_t     stat;
    logic                in_ready, out_load, out_free, enq_ok, acc_reg;
    logic [1:0]          out_kind;
    logic [15:0]         pkt_tag, pkt_len;
    logic [2:0]          pkt_class;
    logic [19:0]         total;
    logic                ovalid_reg;
    cqbs_pkg::out_item_t opay_reg;
    cqbs_pkg::out_item_t opay_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cqbs_pkg::MODE_FIFO;
            for (int c = 0; c < NC; c++)
            begin
                weight_reg[c] <= 8'd1;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == cqbs_pkg::REG_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
            for (int c = 0; c < NC; c++)
            begin
                if (cfg_index == 3'(c + 1))
                begin
                    weight_reg[c] <= cfg_data;
                end
            end
        end
    end

    assign in_ch.ready = in_ready;

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ready)
        begin
            item_reg.tag <= in_ch.payload.packet_tag;
            item_reg.cls <= in_ch.payload.traffic_class;
            item_reg.len <= in_ch.payload.packet_length;
            cap_reg <= in_ch.payload.grant_bytes;
        end
    end

    // The enqueue is carried out in the cycle after acceptance.
    logic enq_pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enq_pend_reg <= 1'b0;
            acc_reg <= 1'b0;
        end
        else
        begin
            enq_pend_reg <= in_ch.valid && in_ready
                            && (in_ch.payload.operation == cqbs_pkg::OP_ENQUEUE);
            if (enq_pend_reg)
            begin
                acc_reg <= enq_ok;
            end
        end
    end

    cqbs_pkg::cmd_t dp_cmd;
    always_comb
    begin
        dp_cmd = cmd;
        dp_cmd.enq = enq_pend_reg;
    end

    cqbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .in_op    (in_ch.payload.operation),
        .mode     (mode_reg),
        .stat     (stat),
        .cmd      (cmd),
        .out_load (out_load),
        .out_kind (out_kind),
        .out_free (out_free)
    );

    cqbs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (stat),
        .item      (item_reg),
        .cap       (cap_reg),
        .mode      (mode_reg),
        .weight    (weight_reg),
        .enq_ok    (enq_ok),
        .pkt_tag   (pkt_tag),
        .pkt_class (pkt_class),
        .pkt_len   (pkt_len),
        .total     (total)
    );

    // Output register; the controller waits while it holds an untaken item.
    assign out_free = !ovalid_reg || out_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload.result_kind = opay_reg.result_kind;
    assign out_ch.payload.accepted = opay_reg.accepted;
    assign out_ch.payload.out_tag = opay_reg.out_tag;
    assign out_ch.payload.out_class = opay_reg.out_class;
    assign out_ch.payload.out_length = opay_reg.out_length;
    assign out_ch.payload.bytes_scheduled = opay_reg.bytes_scheduled;
    assign out_ch.payload.last = opay_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        opay_next = '0;
        opay_next.result_kind = out_kind;
        case (out_kind)
            cqbs_pkg::KIND_ENQ:
            begin
                // The status is enq_ok when loaded with the enqueue, else acc_reg.
                opay_next.accepted = enq_pend_reg ? enq_ok : acc_reg;
                opay_next.last = 1'b1;
            end
            cqbs_pkg::KIND_PKT:
            begin
                opay_next.out_tag = pkt_tag;
                opay_next.out_class = pkt_class;
                opay_next.out_length = pkt_len;
            end
            default:
            begin
                opay_next.bytes_scheduled = total;
                opay_next.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            opay_reg <= opay_next;
        end
    end
endmodule

// ===== sv/cqbs_checker.sv =====
// Port checker for the class queue burst scheduler, bound to the top level.
// Depends on cqbs_pkg and the channel interfaces.
module cqbs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_kind,
    input logic out_last,
    input logic out_accepted
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == cqbs_pkg::KIND_ENQ || out_kind == cqbs_pkg::KIND_PKT
                       || out_kind == cqbs_pkg::KIND_DONE))
        else $error("bad result kind");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == cqbs_pkg::KIND_PKT |-> !out_last && !out_accepted)
        else $error("packet result marked last");
endmodule

bind class_queue_burst_scheduler cqbs_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.payload.result_kind),
    .out_last     (out_ch.payload.last),
    .out_accepted (out_ch.payload.accepted)
);

// ===== tb/tb_class_queue_burst_scheduler.sv =====
// Testbench of the class queue burst scheduler: directed and random enqueue and grant
// items in all four modes, checked against an in-bench prediction of every result.
// Depends on cqbs_pkg, cqbs_if and class_queue_burst_scheduler.
module tb_class_queue_burst_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_WEIGHT0 = 3'd1;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_LENGTH = 400;

    typedef struct packed {
        logic [15:0] tag;
        logic [2:0]  cls;
        logic [15:0] len;
    } descr_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    cqbs_if #(.payload_t(cqbs_pkg::sched_in_t)) in_ch (clk);
    cqbs_if #(.payload_t(cqbs_pkg::out_item_t)) out_ch (clk);

    class_queue_burst_scheduler dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predicted state of the block.
    logic [1:0] mode_model;
    logic [7:0] weight_model [cqbs_pkg::NUM_CLASSES];
    descr_t class_fifo [cqbs_pkg::NUM_CLASSES][$];
    descr_t shared_fifo [$];
    cqbs_pkg::out_item_t expected_results [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int hold_cycles = 0;
    bit hold_req = 0;
    bit hold_ack = 0;
    bit no_idle = 0;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 0;
        in_ch.payload = '0;
        out_ch.ready = 0;
    end

    function automatic void push_result(logic [1:0] kind, logic acc, descr_t d,
                                        logic [19:0] bytes, logic last);
        cqbs_pkg::out_item_t r;
        r.result_kind = kind;
        r.accepted = acc;
        r.out_tag = d.tag;
        r.out_class = d.cls;
        r.out_length = d.len;
        r.bytes_scheduled = bytes;
        r.last = last;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic int queued_total();
        int s;
        s = 0;
        for (int c = 0; c < cqbs_pkg::NUM_CLASSES; c++)
        begin
            s += class_fifo[c].size();
        end
        return s;
    endfunction

    // Sends the head of class c if it fits in the remaining capacity.
    function automatic bit serve_class(int c, int unsigned cap, ref int unsigned total,
                                       ref int n);
        descr_t d;
        d = class_fifo[c][0];
        if (total + d.len > cap)
            return 0;
        total += d.len;
        class_fifo[c].delete(0);
        d.cls = c[2:0];
        push_result(cqbs_pkg::KIND_PKT, 1'b0, d, '0, 1'b0);
        n++;
        return 1;
    endfunction

    function automatic void predict_schedule(cqbs_pkg::sched_in_t it);
        int unsigned total;
        int unsigned cap;
        int n;
        bit acc;
        bit done;
        bit skipped;
        int sent;
        descr_t d;
        total = 0;
        n = 0;
        cap = it.grant_bytes;
        d.tag = it.packet_tag;
        d.cls = it.traffic_class;
        d.len = it.packet_length;
        if (it.operation == cqbs_pkg::OP_ENQUEUE)
        begin
            acc = 0;
            if (it.traffic_class < cqbs_pkg::NUM_CLASSES)
            begin
                if (mode_model == cqbs_pkg::MODE_FIFO &&
                    shared_fifo.size() < cqbs_pkg::FIFO_LIMIT)
                begin
                    shared_fifo.insert(shared_fifo.size(), d);
                    acc = 1;
                end
                else if ((mode_model == cqbs_pkg::MODE_WRR ||
                          mode_model == cqbs_pkg::MODE_APQ) &&
                         class_fifo[it.traffic_class].size() < cqbs_pkg::CLASS_LIMIT)
                begin
                    class_fifo[it.traffic_class].insert(
                        class_fifo[it.traffic_class].size(), d);
                    acc = 1;
                end
            end
            push_result(cqbs_pkg::KIND_ENQ, acc, '0, '0, 1'b1);
            return;
        end
        if (mode_model == cqbs_pkg::MODE_FIFO)
        begin
            while (total < cap && shared_fifo.size() > 0 && n < cqbs_pkg::MAX_PER_GRANT)
            begin
                d = shared_fifo[0];
                if (total + d.len > cap)
                    break;
                total += d.len;
                shared_fifo.delete(0);
                push_result(cqbs_pkg::KIND_PKT, 1'b0, d, '0, 1'b0);
                n++;
            end
        end
        else if (mode_model == cqbs_pkg::MODE_WRR)
        begin
            done = 0;
            while (!done && total < cap && queued_total() > 0 &&
                   n < cqbs_pkg::MAX_PER_GRANT)
            begin
                skipped = 0;
                sent = 0;
                for (int c = 0; c < cqbs_pkg::NUM_CLASSES; c++)
                begin
                    for (int i = 0; i < weight_model[c] && class_fifo[c].size() > 0 &&
                         n < cqbs_pkg::MAX_PER_GRANT; i++)
                    begin
                        if (serve_class(c, cap, total, n))
                            sent++;
                        else
                        begin
                            skipped = 1;
                            break;
                        end
                    end
                end
                if (skipped || sent == 0)
                    done = 1;
            end
        end
        else if (mode_model == cqbs_pkg::MODE_APQ)
        begin
            for (int c = 0; c < cqbs_pkg::NUM_CLASSES; c++)
            begin
                while (class_fifo[c].size() > 0 && total < cap &&
                       n < cqbs_pkg::MAX_PER_GRANT)
                begin
                    if (!serve_class(c, cap, total, n))
                        break;
                end
            end
        end
        push_result(cqbs_pkg::KIND_DONE, 1'b0, '0, total[19:0], 1'b1);
    endfunction

    // Result side: checks each result.
    always @(posedge clk)
    begin
        cqbs_pkg::out_item_t want;
        cqbs_pkg::out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %p", got);
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (got.result_kind !== want.result_kind || got.accepted !== want.accepted ||
                    got.out_tag !== want.out_tag || got.out_class !== want.out_class ||
                    got.out_length !== want.out_length ||
                    got.bytes_scheduled !== want.bytes_scheduled || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Result side: drives ready, with a long hold when one is requested.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_cycles <= HOLD_LENGTH;
            out_ch.ready <= 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 0;
        end
        else
            out_ch.ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 28);
    end

    // Watchdog on cycles with no item moving on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_class_queue_burst_scheduler: errors");
            $finish;
        end
    end

    // The block takes no new item until it has loaded the final result of the one in work,
    // so valid drops after each acceptance without slowing the stream.
    task automatic send_item(cqbs_pkg::sched_in_t it);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 28)
                @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_schedule(it);
        in_ch.valid <= 0;
        @(posedge clk);
    endtask

    task automatic enqueue(logic [15:0] tag, logic [2:0] cls, logic [15:0] len);
        cqbs_pkg::sched_in_t it;
        it = '0;
        it.operation = cqbs_pkg::OP_ENQUEUE;
        it.packet_tag = tag;
        it.traffic_class = cls;
        it.packet_length = len;
        it.grant_bytes = 20'($urandom());
        send_item(it);
    endtask

    task automatic grant(logic [19:0] cap);
        cqbs_pkg::sched_in_t it;
        it = '0;
        it.operation = cqbs_pkg::OP_GRANT;
        it.grant_bytes = cap;
        it.packet_tag = 16'($urandom());
        it.traffic_class = 3'($urandom());
        it.packet_length = 16'($urandom());
        send_item(it);
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        wait_drained();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == cqbs_pkg::REG_MODE)
            mode_model = val[1:0];
        else
            weight_model[idx - REG_WEIGHT0] = val;
    endtask

    task automatic set_weights(int w0, int w1, int w2, int w3, int w4);
        write_reg(REG_WEIGHT0, w0[7:0]);
        write_reg(REG_WEIGHT0 + 3'd1, w1[7:0]);
        write_reg(REG_WEIGHT0 + 3'd2, w2[7:0]);
        write_reg(REG_WEIGHT0 + 3'd3, w3[7:0]);
        write_reg(REG_WEIGHT0 + 3'd4, w4[7:0]);
    endtask

    function automatic logic [15:0] random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 16'($urandom_range(0, 1500));
        else if (r < 90)
            return 16'($urandom());
        return 16'($urandom_range(0, 3));
    endfunction

    function automatic logic [19:0] random_capacity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 20'($urandom_range(0, 6000));
        else if (r < 90)
            return 20'($urandom());
        return (r < 95) ? 20'd0 : 20'hFFFFF;
    endfunction

    task automatic test_fifo_directed();
        write_reg(cqbs_pkg::REG_MODE, cqbs_pkg::MODE_FIFO);
        grant(20'd0);
        grant(20'hFFFFF);
        enqueue(16'h0000, 3'd0, 16'd0);
        enqueue(16'hFFFF, 3'd4, 16'hFFFF);
        enqueue(16'h1234, 3'd5, 16'd10);
        enqueue(16'h4321, 3'd7, 16'd10);
        enqueue(16'hA5A5, 3'd2, 16'd100);
        grant(20'd0);
        // Stops at the second packet, which does not fit.
        grant(20'd50);
        grant(20'hFFFFF);
    endtask

    task automatic test_priority_directed();
        write_reg(cqbs_pkg::REG_MODE, cqbs_pkg::MODE_APQ);
        enqueue(16'h0001, 3'd0, 16'd1000);
        enqueue(16'h0002, 3'd1, 16'd10);
        enqueue(16'h0003, 3'd4, 16'd20);
        enqueue(16'h0004, 3'd6, 16'd20);
        // The class 0 packet does not fit, so the lower classes go first.
        grant(20'd100);
        grant(20'hFFFFF);
    endtask

    task automatic test_wrr_directed();
        write_reg(cqbs_pkg::REG_MODE, cqbs_pkg::MODE_WRR);
        set_weights(2, 0, 255, 1, 1);
        for (int i = 0; i < 4; i++)
            enqueue(i[15:0], i[2:0], 16'd10);
        enqueue(16'h0100, 3'd0, 16'd10);
        enqueue(16'h0101, 3'd0, 16'd500);
        grant(20'd45);
        grant(20'hFFFFF);
        // Class 1 has weight 0: its packet is not sent until the weights are raised.
        grant(20'hFFFFF);
        set_weights(0, 0, 0, 0, 0);
        enqueue(16'h0200, 3'd3, 16'd5);
        grant(20'hFFFFF);
        set_weights(255, 255, 255, 255, 255);
        grant(20'hFFFFF);
    endtask

    task automatic test_discard();
        write_reg(cqbs_pkg::REG_MODE, cqbs_pkg::MODE_DISCARD);
        enqueue(16'hBEEF, 3'd1, 16'd10);
        grant(20'hFFFFF);
    endtask

    task automatic random_phase(int count, bit pressure);
        int r;
        for (int i = 0; i < count; i++)
        begin
            if (pressure && i == count / 3)
            begin
                // Receiver holds off while the sender keeps offering items.
                hold_req = !hold_req;
            end
            r = $urandom_range(0, 99);
            if (r < 62)
                enqueue(16'($urandom()),
                        (r < 58) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7)),
                        random_length());
            else
                grant(random_capacity());
        end
    endtask

    task automatic test_random();
        logic [1:0] modes [6];
        modes = '{cqbs_pkg::MODE_WRR, cqbs_pkg::MODE_FIFO, cqbs_pkg::MODE_APQ,
                  cqbs_pkg::MODE_WRR, cqbs_pkg::MODE_DISCARD, cqbs_pkg::MODE_APQ};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(cqbs_pkg::REG_MODE, modes[p]);
            if (modes[p] == cqbs_pkg::MODE_WRR)
                set_weights(int'($urandom_range(0, 4)), int'($urandom_range(0, 255)),
                            int'($urandom_range(0, 3)), int'($urandom_range(1, 2)),
                            int'($urandom_range(0, 1)));
            no_idle = (p == 3);
            random_phase(65, p == 2);
            // Sender pauses until every result is in.
            wait_drained();
        end
        no_idle = 0;
    endtask

    initial
    begin
        mode_model = cqbs_pkg::MODE_FIFO;
        for (int c = 0; c < cqbs_pkg::NUM_CLASSES; c++)
            weight_model[c] = 8'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        repeat (5) @(posedge clk);
        test_fifo_directed();
        test_priority_directed();
        test_wrr_directed();
        test_discard();
        test_random();
        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_class_queue_burst_scheduler: clean");
        else
            $display("tb_class_queue_burst_scheduler: errors");
        $finish;
    end
endmodule
